@@ rtl/gdo_pkg.sv @@
// ---------------------------------------------------------------------------
// gdo_pkg: shared types and constants for the Gregorian date offset unit
// Holds the calendar table, status codes, state encoding and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package gdo_pkg;

  // Offset bits taken from the request (at most the 16-bit field).
  localparam int OFFSET_BITS = 16;
  // Signed running day count: holds start day plus or minus the offset.
  localparam int DAY_W       = OFFSET_BITS + 2;

  localparam int DAY_BITS    = 5;
  localparam int MON_BITS    = 4;
  localparam int YEAR_BITS   = 14;
  localparam int OFF_FIELD_W = 16;
  localparam int STAT_BITS   = 2;

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 24;

  localparam logic [YEAR_BITS-1:0] MAX_YEAR = YEAR_BITS'(9999);
  localparam logic [MON_BITS-1:0]  MON_JAN  = MON_BITS'(1);
  localparam logic [MON_BITS-1:0]  MON_FEB  = MON_BITS'(2);
  localparam logic [MON_BITS-1:0]  MON_DEC  = MON_BITS'(12);

  // Year mod 25 via reciprocal: q = (y * RECIP25) >> RECIP_SHIFT, exact for 14-bit y.
  localparam int RECIP25     = 5243;
  localparam int RECIP_SHIFT = 17;
  localparam int QUO_W       = 10;
  localparam int PROD_W      = YEAR_BITS + 13;
  localparam int R25_W       = 5;
  localparam logic [R25_W-1:0] R25_TOP = R25_W'(24);

  localparam logic [DAY_BITS-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [DAY_BITS-1:0] FEB_LEAP = 5'd29;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_QUO   = 6'b000010,
    S_REM   = 6'b000100,
    S_CHECK = 6'b001000,
    S_WALK  = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;     // capture request fields
    logic quo;      // register year / 25
    logic rem;      // register year mod 25
    logic check;    // validate start date, seed day count
    logic step;     // one month step of the walk
    logic emit;     // move result into output register
  } gdo_cmd_t;

  typedef struct packed {
    logic bad_date;
    logic walk_done;
    logic range_err;
  } gdo_sts_t;

  // Gregorian leap year from the low year bits and year mod 25.
  function automatic logic is_leap(input logic [3:0] y_lo, input logic [R25_W-1:0] r25);
    is_leap = (y_lo[1:0] == 2'b00) && ((r25 != '0) || (y_lo == 4'd0));
  endfunction

  function automatic logic [DAY_BITS-1:0] days_in(input logic [MON_BITS-1:0] m,
                                                  input logic leap);
    logic [MON_BITS-1:0] idx;
    idx = m - MON_JAN;
    if (m == MON_FEB) begin
      days_in = leap ? FEB_LEAP : MONTH_LEN[1];
    end else if ((m >= MON_JAN) && (m <= MON_DEC)) begin
      days_in = MONTH_LEN[idx];
    end else begin
      days_in = '0;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/gdo_ctrl.sv @@
// ---------------------------------------------------------------------------
// gdo_ctrl: request sequencer
// One-hot state machine that steps a request through capture, year
// remainder, validation and the month walk, and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module gdo_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output gdo_pkg::gdo_cmd_t      cmd_o,
  input  wire gdo_pkg::gdo_sts_t sts_i
);
  import gdo_pkg::*;

  state_e state_q, state_d;
  logic   ovld_q, ovld_d;
  logic   out_free;

  assign out_free      = !ovld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovld_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ovld_d  = ovld_q && !m_axis_tready;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = S_QUO;
        end
      end
      S_QUO: begin
        cmd_o.quo = 1'b1;
        state_d   = S_REM;
      end
      S_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.bad_date ? S_FIN : S_WALK;
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.walk_done || sts_i.range_err) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          ovld_d     = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gdo_dp.sv @@
// ---------------------------------------------------------------------------
// gdo_dp: date datapath
// Holds the working date, year mod 25, the signed day count and the
// output register; does one month step per command.
// ---------------------------------------------------------------------------
`default_nettype none

module gdo_dp (
  input  wire logic                                clk_i,
  input  wire logic                                req_type_i,
  input  wire logic [gdo_pkg::DAY_BITS-1:0]        start_day_i,
  input  wire logic [gdo_pkg::MON_BITS-1:0]        start_month_i,
  input  wire logic [gdo_pkg::YEAR_BITS-1:0]       start_year_i,
  input  wire logic [gdo_pkg::OFF_FIELD_W-1:0]     day_offset_i,
  input  wire gdo_pkg::gdo_cmd_t                   cmd_i,
  output gdo_pkg::gdo_sts_t                        sts_o,
  output logic [gdo_pkg::DAY_BITS-1:0]             end_day_o,
  output logic [gdo_pkg::MON_BITS-1:0]             end_month_o,
  output logic [gdo_pkg::YEAR_BITS-1:0]            end_year_o,
  output logic [gdo_pkg::STAT_BITS-1:0]            status_o
);
  import gdo_pkg::*;

  localparam logic [DAY_W-1:0] OFF_MASK = DAY_W'((64'd1 << OFFSET_BITS) - 64'd1);

  logic                  dir_q;
  logic [DAY_BITS-1:0]   d0_q;
  logic [MON_BITS-1:0]   mon_q, mon_d;
  logic [YEAR_BITS-1:0]  year_q, year_d;
  logic [DAY_W-1:0]      off_q;
  logic [QUO_W-1:0]      quo_q;
  logic [R25_W-1:0]      r25_q, r25_d;
  logic signed [DAY_W-1:0] day_q, day_d;
  status_e               stat_q, stat_d;

  logic [DAY_BITS-1:0]   res_day_q;
  logic [MON_BITS-1:0]   res_mon_q;
  logic [YEAR_BITS-1:0]  res_year_q;
  status_e               res_stat_q;

  logic [PROD_W-1:0]     prod;
  logic [YEAR_BITS-1:0]  quo25;
  logic [DAY_BITS-1:0]   dim_cur, dim_new, dim_start;
  logic signed [DAY_W-1:0] dim_cur_s, dim_new_s, d0_s;
  logic [MON_BITS-1:0]   mon_n;
  logic [YEAR_BITS-1:0]  year_n;
  logic [R25_W-1:0]      r25_n;
  logic                  done, range_err, bad_date;

  assign prod  = PROD_W'(year_q) * PROD_W'(RECIP25);
  assign quo25 = (YEAR_BITS'(quo_q) << 4) + (YEAR_BITS'(quo_q) << 3) + YEAR_BITS'(quo_q);

  assign dim_start = days_in(mon_q, is_leap(year_q[3:0], r25_q));
  assign dim_cur   = dim_start;
  assign dim_cur_s = $signed(DAY_W'(dim_cur));
  assign d0_s      = $signed(DAY_W'(d0_q));

  assign bad_date = (mon_q < MON_JAN) || (mon_q > MON_DEC) || (year_q > MAX_YEAR) ||
                    (d0_q == '0) || (d0_q > dim_start);

  // Neighbor month of the walk, with year and mod-25 wrap.
  always_comb begin
    mon_n     = mon_q;
    year_n    = year_q;
    r25_n     = r25_q;
    range_err = 1'b0;
    if (!dir_q) begin
      done = (day_q <= dim_cur_s);
      if (mon_q == MON_DEC) begin
        mon_n     = MON_JAN;
        range_err = !done && (year_q >= MAX_YEAR);
        year_n    = year_q + YEAR_BITS'(1);
        r25_n     = (r25_q == R25_TOP) ? '0 : r25_q + R25_W'(1);
      end else begin
        mon_n = mon_q + MON_BITS'(1);
      end
    end else begin
      done = (day_q > $signed(DAY_W'(0)));
      if (mon_q == MON_JAN) begin
        mon_n     = MON_DEC;
        range_err = !done && (year_q == '0);
        year_n    = year_q - YEAR_BITS'(1);
        r25_n     = (r25_q == '0) ? R25_TOP : r25_q - R25_W'(1);
      end else begin
        mon_n = mon_q - MON_BITS'(1);
      end
    end
  end

  assign dim_new   = days_in(mon_n, is_leap(year_n[3:0], r25_n));
  assign dim_new_s = $signed(DAY_W'(dim_new));

  assign sts_o.bad_date  = bad_date;
  assign sts_o.walk_done = done;
  assign sts_o.range_err = range_err;

  always_comb begin
    mon_d  = mon_q;
    year_d = year_q;
    r25_d  = r25_q;
    day_d  = day_q;
    stat_d = stat_q;
    if (cmd_i.rem) begin
      r25_d = R25_W'(year_q - quo25);
    end
    if (cmd_i.check) begin
      stat_d = bad_date ? ST_BAD_DATE : ST_OK;
      day_d  = dir_q ? (d0_s - $signed(off_q)) : (d0_s + $signed(off_q));
    end
    if (cmd_i.step) begin
      if (range_err) begin
        stat_d = ST_RANGE;
      end else if (!done) begin
        mon_d  = mon_n;
        year_d = year_n;
        r25_d  = r25_n;
        day_d  = dir_q ? (day_q + dim_new_s) : (day_q - dim_cur_s);
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dir_q  <= req_type_i;
      d0_q   <= start_day_i;
      mon_q  <= start_month_i;
      year_q <= start_year_i;
      off_q  <= DAY_W'(day_offset_i) & OFF_MASK;
    end else begin
      mon_q  <= mon_d;
      year_q <= year_d;
    end
    if (cmd_i.quo) begin
      quo_q <= QUO_W'(prod >> RECIP_SHIFT);
    end
    r25_q  <= r25_d;
    day_q  <= day_d;
    stat_q <= stat_d;
    if (cmd_i.emit) begin
      res_stat_q <= stat_q;
      if (stat_q == ST_OK) begin
        res_day_q  <= DAY_BITS'(day_q);
        res_mon_q  <= mon_q;
        res_year_q <= year_q;
      end else begin
        res_day_q  <= '0;
        res_mon_q  <= '0;
        res_year_q <= '0;
      end
    end
  end

  assign end_day_o   = res_day_q;
  assign end_month_o = res_mon_q;
  assign end_year_o  = res_year_q;
  assign status_o    = res_stat_q;

endmodule

`default_nettype wire

@@ rtl/gregorian_date_offset_unit.sv @@
// ---------------------------------------------------------------------------
// gregorian_date_offset_unit: Gregorian date plus/minus a day offset
// Validates a start date and walks month by month to the date a given
// number of days later or earlier, returning the date and a status.
// ---------------------------------------------------------------------------
// Sequence: an invalid date passes capture, quotient, remainder and check
//   before the result; a valid date also walks the months, one month per
//   cycle in the datapath walk.
// Throughput: one request at a time; the next request is taken once the
//   current result has been moved to the output register.
// Reset: rst_ni asynchronous, active low; clears state and result valid only.
`default_nettype none

module gregorian_date_offset_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request channel.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [4:0] start_day, [8:5] start_month, [22:9] start_year,
  // [38:23] day_offset, [39] zero fill
  input  wire logic [gdo_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [0] req_type (0 add, 1 subtract)
  input  wire logic                          s_axis_tuser,
  // Result channel.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [4:0] end_day, [8:5] end_month, [22:9] end_year, [23] zero fill
  output logic [gdo_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [1:0] status (0 ok, 1 invalid date, 2 year out of range)
  output logic [gdo_pkg::STAT_BITS-1:0]      m_axis_tuser
);
  import gdo_pkg::*;

  gdo_cmd_t              cmd;
  gdo_sts_t              sts;
  logic [DAY_BITS-1:0]   end_day;
  logic [MON_BITS-1:0]   end_month;
  logic [YEAR_BITS-1:0]  end_year;

  // Sequence the request; hold the result until taken.
  gdo_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  // Unpack request fields straight into the datapath capture registers.
  gdo_dp u_dp (
    .clk_i         (clk_i),
    .req_type_i    (s_axis_tuser),
    .start_day_i   (s_axis_tdata[4:0]),
    .start_month_i (s_axis_tdata[8:5]),
    .start_year_i  (s_axis_tdata[22:9]),
    .day_offset_i  (s_axis_tdata[38:23]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .end_day_o     (end_day),
    .end_month_o   (end_month),
    .end_year_o    (end_year),
    .status_o      (m_axis_tuser)
  );

  // Pack the result; top bit is fill.
  assign m_axis_tdata = {1'b0, end_year, end_month, end_day};

endmodule

`default_nettype wire

@@ rtl/gdo_checker.sv @@
// ---------------------------------------------------------------------------
// gdo_checker: port-level checks for the date offset unit
// Watches the request and result channels and flags illegal behavior.
// ---------------------------------------------------------------------------
`default_nettype none

module gdo_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [gdo_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [gdo_pkg::STAT_BITS-1:0] m_axis_tuser
);
  import gdo_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // One request at a time: ready drops after a request is taken.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // Status code is one of the defined codes.
  a_stat_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_BAD_DATE) ||
                      (m_axis_tuser == ST_RANGE))
    else $error("undefined status");

  // Error results carry a zero date.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("error result with nonzero date");

  // Good results carry a real calendar date.
  a_ok_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_OK) |->
      (m_axis_tdata[4:0] != '0) && (m_axis_tdata[8:5] >= MON_JAN) &&
      (m_axis_tdata[8:5] <= MON_DEC) && (m_axis_tdata[22:9] <= MAX_YEAR))
    else $error("ok result with bad date");

endmodule

bind gregorian_date_offset_unit gdo_checker u_gdo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
